>>> src/sorted_quote_book_update_macros.svh
// Assertion macros used by the checker file.
`ifndef SORTED_QUOTE_BOOK_UPDATE_MACROS_SVH
`define SORTED_QUOTE_BOOK_UPDATE_MACROS_SVH
// Antecedent implies consequent on the next edge, outside reset.
`define SQB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted quote book: assertion failed");
// Antecedent implies consequent on the same edge, outside reset.
`define SQB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted quote book: assertion failed");
`endif

>>> src/sqb_pkg.sv
// Package with shared types and constants of the sorted quote book.
`timescale 1ns / 1ps
`default_nettype none
package sqb_pkg;
   localparam int DefaultDepth = 16;
   localparam int SrcW = 8;
   localparam int PriceW = 32;
   localparam int StampW = 64;
   localparam int SizeW = 32;

   typedef struct packed {
      logic [SrcW-1:0] src;
      logic signed [PriceW-1:0] price;
      logic [StampW-1:0] stamp;
      logic [SizeW-1:0] size;
   } entry_type;

   // Command broadcast to every cell of a side.
   typedef struct packed {
      logic remove;   // phase 1: close the gap of a matching source
      logic insert;   // phase 2: place a new or updated entry
      logic high_first;
      entry_type ent;
   } cmd_type;
endpackage
`default_nettype wire

>>> src/sqb_cell.sv
// One slot of a sorted side; talks to its left and right neighbors.
`timescale 1ns / 1ps
`default_nettype none
module sqb_cell
   import sqb_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cmd_type   cmd,
   input  wire entry_type left_ent,
   input  wire logic      left_valid,
   input  wire logic      left_takes,   // left neighbor or earlier accepts new entry
   input  wire logic      left_hit,     // some cell left of here matched the source
   input  wire entry_type right_ent,
   input  wire logic      right_valid,
   output entry_type      ent_out,
   output logic           valid_out,
   output logic           takes_out,
   output logic           hit_out
);
   entry_type ent_ff, ent_in;
   logic valid_ff, valid_in, after_ff, after_in, better, same, beats, match;

   assign match = valid_ff && (ent_ff.src == cmd.ent.src);
   assign better = cmd.high_first ? (cmd.ent.price > ent_ff.price)
                                  : (cmd.ent.price < ent_ff.price);
   assign same = (cmd.ent.price == ent_ff.price);
   // A new entry goes ahead of this one only if its price is strictly better.
   // A replaced quote keeps its old rank among equal prices: it also goes
   // ahead of an equal entry that stood behind it before the remove pass.
   assign beats = !valid_ff || better || (after_ff && same);
   assign takes_out = left_takes || beats;
   assign hit_out = left_hit || match;

   always_comb begin
      ent_in = ent_ff;
      valid_in = valid_ff;
      after_in = after_ff;
      if (cmd.remove) begin
         after_in = left_hit || match;
         if (left_hit || match) begin
            ent_in = right_ent;
            valid_in = right_valid;
         end
      end else if (cmd.insert) begin
         if (left_takes) begin
            ent_in = left_ent;
            valid_in = left_valid;
         end else if (beats) begin
            ent_in = cmd.ent;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         after_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         after_ff <= after_in;
      end
      ent_ff <= ent_in;
   end

   assign ent_out = ent_ff;
   assign valid_out = valid_ff;
endmodule
`default_nettype wire

>>> src/sqb_side.sv
// A chain of cells forming one sorted side with its fill count.
`timescale 1ns / 1ps
`default_nettype none
module sqb_side
   import sqb_pkg::*;
#(
   parameter int TableDepth = DefaultDepth
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      remove,
   input  wire logic      insert,
   input  wire logic      high_first,
   input  wire entry_type new_ent,
   output logic           hit,
   output logic           full,
   output entry_type      top_ent,
   output logic           top_valid,
   output logic [$clog2(TableDepth+1)-1:0] fill
);
   localparam int FillW = $clog2(TableDepth + 1);
   cmd_type cmd;
   entry_type ents [TableDepth+1];
   logic valids [TableDepth+1];
   logic takes [TableDepth+1];
   logic hits [TableDepth+1];
   logic [FillW-1:0] fill_ff, fill_in;

   assign cmd = '{remove: remove, insert: insert, high_first: high_first, ent: new_ent};
   assign takes[0] = 1'b0;
   assign hits[0] = 1'b0;
   assign ents[TableDepth] = new_ent;
   assign valids[TableDepth] = 1'b0;

   for (genvar i = 0; i < TableDepth; i++) begin : g_cell
      entry_type le;
      logic lv;
      if (i == 0) begin : g_first
         assign le = new_ent;
         assign lv = 1'b0;
      end else begin : g_rest
         assign le = ents[i-1];
         assign lv = valids[i-1];
      end
      entry_type eo;
      logic vo;
      sqb_cell u_cell (
         .clock(clock), .reset(reset), .cmd(cmd),
         .left_ent(le), .left_valid(lv), .left_takes(takes[i]), .left_hit(hits[i]),
         .right_ent(ents[i+1]), .right_valid(valids[i+1]),
         .ent_out(eo), .valid_out(vo), .takes_out(takes[i+1]),
         .hit_out(hits[i+1])
      );
      assign ents[i] = eo;
      assign valids[i] = vo;
   end

   assign hit = hits[TableDepth];
   assign full = (fill_ff == FillW'(TableDepth));

   always_comb begin
      fill_in = fill_ff;
      if (remove && hit) begin
         fill_in = fill_ff - 1'b1;
      end else if (insert) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign fill = fill_ff;
   assign top_ent = ents[0];
   assign top_valid = valids[0];
endmodule
`default_nettype wire

>>> src/sorted_quote_book_update.sv
// Top level of the sorted quote book update block.
// Usage: each req_ transfer carries one source's latest bid and ask quote.
// The block keeps a bid side (highest price first) and an ask side (lowest
// price first), each a chain of TABLE_DEPTH cells holding at most one quote per
// source. A positive price replaces that source's quote, a price of zero or
// below withdraws it. Ties in price keep arrival order, and a replaced quote
// keeps its old rank among entries of the same price.
// Steps: in the cycle after acceptance every cell of each side compares its
// source with the request and a held entry of that source is closed up out of
// the chain. In the next cycle a live quote is put in by shifting the worse
// entries one cell right. The result register is loaded in the report step
// that follows the insert pass, once the output register is free.
// A new request is taken only once the last one has been reported: the accept,
// remove, insert and report steps run one after another.
// The result is held in an output register; the next request may be accepted
// while it still waits, but that request's report waits until it is taken.
// Reset empties both sides and clears the pending result.
// When rsp_stall is high the result holds steady; req_stall marks a busy sequencer.
`timescale 1ns / 1ps
`default_nettype none
module sorted_quote_book_update
   import sqb_pkg::*;
#(
   parameter int TABLE_DEPTH = DefaultDepth
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire logic [7:0]  req_source_id,
   input  wire logic signed [31:0] req_bid_price,
   input  wire logic [63:0] req_bid_stamp,
   input  wire logic [31:0] req_bid_size,
   input  wire logic signed [31:0] req_ask_price,
   input  wire logic [63:0] req_ask_stamp,
   input  wire logic [31:0] req_ask_size,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output logic [7:0]  rsp_top_bid_source,
   output logic signed [31:0] rsp_top_bid_price,
   output logic [31:0] rsp_top_bid_size,
   output logic [7:0]  rsp_top_ask_source,
   output logic signed [31:0] rsp_top_ask_price,
   output logic [31:0] rsp_top_ask_size,
   output logic [4:0]  rsp_bid_entries,
   output logic [4:0]  rsp_ask_entries,
   output logic [1:0]  rsp_dropped
);
   localparam int FillW = $clog2(TABLE_DEPTH + 1);
   // Sequencer states.
   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StRemove = 2'd1;
   localparam logic [1:0] StInsert = 2'd2;
   localparam logic [1:0] StReport = 2'd3;

   logic [1:0] state_ff, state_in;
   entry_type bid_ff, bid_in, ask_ff, ask_in;
   logic bid_live, ask_live, bid_hit, ask_hit, bid_full, ask_full;
   logic bid_ins, ask_ins;
   logic [1:0] drop_ff, drop_in;
   entry_type bid_top, ask_top;
   logic bid_tv, ask_tv;
   logic [FillW-1:0] bid_fill, ask_fill;
   logic out_valid_ff, out_valid_in, accept, out_free;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != StIdle);
   assign accept = req_valid && !req_stall;

   assign bid_live = bid_ff.price > 0;
   assign ask_live = ask_ff.price > 0;
   // After the remove pass an entry of this source is gone, so the fill alone
   // decides whether a live quote fits.
   assign bid_ins = (state_ff == StInsert) && bid_live && !bid_full;
   assign ask_ins = (state_ff == StInsert) && ask_live && !ask_full;

   sqb_side #(.TableDepth(TABLE_DEPTH)) u_bid (
      .clock(clock), .reset(reset), .remove(state_ff == StRemove), .insert(bid_ins),
      .high_first(1'b1), .new_ent(bid_ff), .hit(bid_hit), .full(bid_full),
      .top_ent(bid_top), .top_valid(bid_tv), .fill(bid_fill)
   );
   sqb_side #(.TableDepth(TABLE_DEPTH)) u_ask (
      .clock(clock), .reset(reset), .remove(state_ff == StRemove), .insert(ask_ins),
      .high_first(1'b0), .new_ent(ask_ff), .hit(ask_hit), .full(ask_full),
      .top_ent(ask_top), .top_valid(ask_tv), .fill(ask_fill)
   );

   always_comb begin
      state_in = state_ff;
      bid_in = bid_ff;
      ask_in = ask_ff;
      drop_in = drop_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               bid_in = '{src: req_source_id, price: req_bid_price,
                          stamp: req_bid_stamp, size: req_bid_size};
               ask_in = '{src: req_source_id, price: req_ask_price,
                          stamp: req_ask_stamp, size: req_ask_size};
               state_in = StRemove;
            end
         end
         StRemove: begin
            // A held entry frees its slot; record a drop only for a new source.
            drop_in = {ask_live && !ask_hit && ask_full, bid_live && !bid_hit && bid_full};
            state_in = StInsert;
         end
         StInsert: begin
            state_in = StReport;
         end
         StReport: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
      bid_ff <= bid_in;
      ask_ff <= ask_in;
      drop_ff <= drop_in;
      if (state_ff == StReport && out_free) begin
         rsp_top_bid_source <= bid_tv ? bid_top.src : '0;
         rsp_top_bid_price <= bid_tv ? bid_top.price : '0;
         rsp_top_bid_size <= bid_tv ? bid_top.size : '0;
         rsp_top_ask_source <= ask_tv ? ask_top.src : '0;
         rsp_top_ask_price <= ask_tv ? ask_top.price : '0;
         rsp_top_ask_size <= ask_tv ? ask_top.size : '0;
         rsp_bid_entries <= 5'(bid_fill);
         rsp_ask_entries <= 5'(ask_fill);
         rsp_dropped <= drop_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
endmodule
`default_nettype wire

>>> src/sqb_checker.sv
// Port-level checker for the sorted quote book, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_quote_book_update_macros.svh"
module sqb_checker
   import sqb_pkg::*;
#(
   parameter int TableDepth = DefaultDepth
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic [4:0] rsp_bid_entries,
   input wire logic [4:0] rsp_ask_entries,
   input wire logic [1:0] rsp_dropped,
   input wire logic [31:0] rsp_top_bid_price
);
   logic bid_drop, ask_drop, bid_full, ask_full, bid_empty;

   assign bid_drop = rsp_valid && rsp_dropped[0];
   assign ask_drop = rsp_valid && rsp_dropped[1];
   assign bid_full = (rsp_bid_entries == 5'(TableDepth));
   assign ask_full = (rsp_ask_entries == 5'(TableDepth));
   assign bid_empty = rsp_valid && (rsp_bid_entries == 5'd0);

   // The block is busy right after it takes a request.
   `SQB_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)
   // A stalled result stays offered.
   `SQB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // A drop is only reported against a full side.
   `SQB_ASSERT_NOW(a_drop_full_bid, clock, reset, bid_drop, bid_full)
   `SQB_ASSERT_NOW(a_drop_full_ask, clock, reset, ask_drop, ask_full)
   // An empty bid side reports a zero price.
   `SQB_ASSERT_NOW(a_empty_bid, clock, reset, bid_empty, rsp_top_bid_price == 32'd0)
endmodule

bind sorted_quote_book_update sqb_checker #(.TableDepth(TABLE_DEPTH)) u_sqb_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_bid_entries(rsp_bid_entries),
   .rsp_ask_entries(rsp_ask_entries), .rsp_dropped(rsp_dropped),
   .rsp_top_bid_price(rsp_top_bid_price)
);
`default_nettype wire

>>> test/sorted_quote_book_update_test.sv
// Self-checking testbench for the sorted quote book update block.
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
   logic [7:0] src;
   logic signed [31:0] price;
   logic [63:0] stamp;
   logic [31:0] size;
} quote_type;

typedef struct {
   logic [7:0] bsrc;
   logic signed [31:0] bprice;
   logic [31:0] bsize;
   logic [7:0] asrc;
   logic signed [31:0] aprice;
   logic [31:0] asize;
   logic [4:0] bcnt;
   logic [4:0] acnt;
   logic [1:0] drop;
} tops_type;

// Checker that holds its own copy of both sides of the book and the queue of
// expected tops.
class quote_book_board;
   quote_type bids[$];
   quote_type asks[$];
   tops_type pending_tops[$];
   int depth;
   int errors;

   function new(int d);
      depth = d;
      errors = 0;
   endfunction

   // Applies one side's quote; returns 1 when an insert found the side full.
   function bit apply_quote(ref quote_type side[$], input quote_type q,
                            input bit high_first);
      int at;
      int k;
      at = -1;
      foreach (side[i]) begin
         if (at < 0 && side[i].src == q.src) at = i;
      end
      if (at >= 0) begin
         side.delete(at);
      end else if (q.price <= 0) begin
         return 0;
      end else if (side.size() >= depth) begin
         return 1;
      end
      if (q.price > 0) begin
         // An updated quote ranks as it did: it goes back to the same index
         // and is then moved by the stable sort, so it keeps its position
         // against equal prices.
         if (at >= 0) begin
            side.insert(at, q);
         end else begin
            side = {side, q};
         end
         for (int i = 1; i < side.size(); i++) begin
            quote_type key;
            key = side[i];
            k = i;
            while (k > 0 && (high_first ? key.price > side[k-1].price
                                        : key.price < side[k-1].price)) begin
               side[k] = side[k-1];
               k--;
            end
            side[k] = key;
         end
      end
      return 0;
   endfunction

   function void note_request(quote_type bq, quote_type aq);
      tops_type t;
      t.drop[0] = apply_quote(bids, bq, 1'b1);
      t.drop[1] = apply_quote(asks, aq, 1'b0);
      t.bcnt = 5'(bids.size());
      t.acnt = 5'(asks.size());
      if (bids.size() > 0) begin
         t.bsrc = bids[0].src; t.bprice = bids[0].price; t.bsize = bids[0].size;
      end else begin
         t.bsrc = '0; t.bprice = '0; t.bsize = '0;
      end
      if (asks.size() > 0) begin
         t.asrc = asks[0].src; t.aprice = asks[0].price; t.asize = asks[0].size;
      end else begin
         t.asrc = '0; t.aprice = '0; t.asize = '0;
      end
      pending_tops = {pending_tops, t};
   endfunction

   task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   task check_result(tops_type got);
      tops_type want;
      if (pending_tops.size() == 0) begin
         report_mismatch("result with no request outstanding");
         return;
      end
      want = pending_tops.pop_front();
      if (got.bsrc !== want.bsrc) report_mismatch("top_bid_source");
      if (got.bprice !== want.bprice) report_mismatch("top_bid_price");
      if (got.bsize !== want.bsize) report_mismatch("top_bid_size");
      if (got.asrc !== want.asrc) report_mismatch("top_ask_source");
      if (got.aprice !== want.aprice) report_mismatch("top_ask_price");
      if (got.asize !== want.asize) report_mismatch("top_ask_size");
      if (got.bcnt !== want.bcnt) report_mismatch("bid_entries");
      if (got.acnt !== want.acnt) report_mismatch("ask_entries");
      if (got.drop !== want.drop) report_mismatch("dropped");
   endtask
endclass

module sorted_quote_book_update_test;
   import sqb_pkg::*;

   localparam int Depth = DefaultDepth;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_source_id = '0;
   logic signed [31:0] req_bid_price = '0;
   logic [63:0] req_bid_stamp = '0;
   logic [31:0] req_bid_size = '0;
   logic signed [31:0] req_ask_price = '0;
   logic [63:0] req_ask_stamp = '0;
   logic [31:0] req_ask_size = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [7:0] rsp_top_bid_source;
   logic signed [31:0] rsp_top_bid_price;
   logic [31:0] rsp_top_bid_size;
   logic [7:0] rsp_top_ask_source;
   logic signed [31:0] rsp_top_ask_price;
   logic [31:0] rsp_top_ask_size;
   logic [4:0] rsp_bid_entries;
   logic [4:0] rsp_ask_entries;
   logic [1:0] rsp_dropped;

   // Idle rates in percent for the sender and the receiver.
   int send_idle = 0;
   int recv_idle = 0;
   quote_book_board book;

   always #6 clock = ~clock;

   sorted_quote_book_update #(.TABLE_DEPTH(Depth)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_source_id(req_source_id),
      .req_bid_price(req_bid_price), .req_bid_stamp(req_bid_stamp),
      .req_bid_size(req_bid_size),
      .req_ask_price(req_ask_price), .req_ask_stamp(req_ask_stamp),
      .req_ask_size(req_ask_size),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_top_bid_source(rsp_top_bid_source), .rsp_top_bid_price(rsp_top_bid_price),
      .rsp_top_bid_size(rsp_top_bid_size),
      .rsp_top_ask_source(rsp_top_ask_source), .rsp_top_ask_price(rsp_top_ask_price),
      .rsp_top_ask_size(rsp_top_ask_size),
      .rsp_bid_entries(rsp_bid_entries), .rsp_ask_entries(rsp_ask_entries),
      .rsp_dropped(rsp_dropped)
   );

   initial book = new(Depth);

   // The receiver picks a new stall value at each falling edge once reset is
   // over. Results are sampled at the rising edge where the transfer happens.
   always @(negedge clock) begin
      if (!reset) rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      tops_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.bsrc = rsp_top_bid_source;
         got.bprice = rsp_top_bid_price;
         got.bsize = rsp_top_bid_size;
         got.asrc = rsp_top_ask_source;
         got.aprice = rsp_top_ask_price;
         got.asize = rsp_top_ask_size;
         got.bcnt = rsp_bid_entries;
         got.acnt = rsp_ask_entries;
         got.drop = rsp_dropped;
         book.check_result(got);
      end
   end

   // Offers one item and holds it until the transfer; optionally leaves a
   // random gap before it. Inputs change only at falling edges. The item stays
   // on the ports after the transfer until the next call or drain replaces it.
   task automatic send_quote(input logic [7:0] src, input logic signed [31:0] bp,
                             input logic signed [31:0] ap);
      quote_type bq;
      quote_type aq;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      bq.src = src; bq.price = bp;
      bq.stamp = {$urandom, $urandom}; bq.size = $urandom;
      aq.src = src; aq.price = ap;
      aq.stamp = {$urandom, $urandom}; aq.size = $urandom;
      req_valid <= 1'b1;
      req_source_id <= src;
      req_bid_price <= bp;
      req_bid_stamp <= bq.stamp;
      req_bid_size <= bq.size;
      req_ask_price <= ap;
      req_ask_stamp <= aq.stamp;
      req_ask_size <= aq.size;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(bq, aq);
      @(negedge clock);
   endtask

   // Mostly small positive prices so ties and reorders are common; some
   // withdrawals with zero or negative prices, some extreme values.
   function automatic logic signed [31:0] pick_price();
      int r;
      r = $urandom_range(99);
      if (r < 60) return $urandom_range(12, 1) <<< 16;
      if (r < 70) return 0;
      if (r < 78) return -$signed(32'($urandom_range(1000)));
      if (r < 84) return 32'sh7fffffff;
      if (r < 88) return 32'sh80000000;
      return $urandom;
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      while (book.pending_tops.size() > 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_phase(input int n);
      int pool;
      for (int i = 0; i < n; i++) begin
         // A narrow source pool exercises replacement and removal; a wide one
         // keeps the tables full so that drops happen.
         pool = (i % 200 < 100) ? 20 : 255;
         send_quote(8'($urandom_range(pool)), pick_price(), pick_price());
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      rsp_stall <= 1'b0;

      // Directed part: empty-side withdraw, extremes, equal-price order,
      // replacement, fill to capacity and the drop of a further insert.
      send_quote(8'd0, 32'sh0, -32'sd1);
      send_quote(8'd255, 32'sh7fffffff, 32'sh80000000);
      send_quote(8'd1, 32'sh00010000, 32'sh00010000);
      send_quote(8'd2, 32'sh00010000, 32'sh00010000);
      send_quote(8'd1, 32'sh00020000, 32'sh00000001);
      send_quote(8'd255, 32'sh0, 32'sh7fffffff);
      for (int i = 3; i < 19; i++) send_quote(i[7:0], 32'sh00030000, 32'sh00030000);
      send_quote(8'd200, 32'sh00040000, 32'sh00000002);
      send_quote(8'd2, -32'sd5, 32'sh0);
      drain();

      send_idle = 23; recv_idle = 75;
      random_phase(500);
      // Hold off until every expected result is back before the next phase.
      drain();
      send_idle = 75; recv_idle = 23;
      random_phase(500);
      drain();
      send_idle = 0; recv_idle = 0;
      random_phase(530);
      drain();

      if (book.errors == 0) begin
         $display("sorted_quote_book_update_test: PASS");
      end else begin
         $display("sorted_quote_book_update_test: FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("sorted_quote_book_update_test: FAIL");
      $finish;
   end
endmodule

`default_nettype wire
